/* rtl/core/kpm_pkg.sv */
// Shared types and constants for the keypad PIN code matcher.
package kpm_pkg;

  localparam int BUFFER_SLOTS_DEF  = 16;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PIN_DIGITS_DEF    = 8;

  localparam int ENTRY_DIGITS = 15;
  localparam int ENTRY_W      = 4 * ENTRY_DIGITS;
  localparam int SLOT_W       = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [15:0] GAP_LIMIT_RST   = 16'd3000;
  localparam logic [15:0] ENTRY_LIMIT_RST = 16'd10000;
  localparam logic [15:0] TIMER_MAX       = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    REQ_DIGIT = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_t;

  typedef struct packed {
    req_t        req_type;
    logic [3:0]  key_digit;
    logic [3:0]  load_slot;
    logic [3:0]  load_length;
    logic [31:0] load_code;
  } in_word_t;

  typedef struct packed {
    logic               is_match;
    logic [3:0]         match_slot;
    logic [ENTRY_W-1:0] entered_code;
    logic [3:0]         entered_length;
    logic               cause;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  slot;
    logic [3:0]  length;
    logic [31:0] code;
  } load_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] code;
    logic [3:0]         count;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tok_t;

endpackage

/* rtl/core/keypad_pin_code_matcher_unit.sv */
// Top level of the keypad PIN code matcher: controller and a row of table cells.
//
//  channel  ports                          handshake
//  input    start, busy, in_word           taken when start high and busy low
//  result   out_valid, out_word            one-cycle strobe, never held off
//  config   cfg_we, cfg_index, cfg_wdata   written on any edge with cfg_we high
//
// A digit runs one search word down the chain of TABLE_ENTRIES cells, one cell per
// cycle; busy stays high until the word leaves the last cell, and its result strobes
// in the first cycle that busy is low. Ticks, loads, flushes and a digit into a full
// buffer do not raise busy; any result of a tick strobes in the cycle after it is taken.
// Synchronous reset empties the entry, clears every table length and restores limits.
// The result side has no stall.
module keypad_pin_code_matcher_unit import kpm_pkg::*; #(
  parameter int BUFFER_SLOTS  = BUFFER_SLOTS_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int PIN_DIGITS    = PIN_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  load_t  load;
  entry_t entry;
  tok_t   tok_chain [TABLE_ENTRIES+1];
  tok_t   tok_head;

  kpm_ctrl #(
    .BUFFER_SLOTS (BUFFER_SLOTS),
    .PIN_DIGITS   (PIN_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .load      (load),
    .entry     (entry),
    .tok_head  (tok_head),
    .tok_tail  (tok_chain[TABLE_ENTRIES])
  );

  assign tok_chain[0] = tok_head;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    kpm_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (load),
      .entry   (entry),
      .tok_in  (tok_chain[g]),
      .tok_out (tok_chain[g+1])
    );
  end

endmodule

/* rtl/core/kpm_cell.sv */
// One table cell: holds a PIN, compares it with the entry as the search word passes.
module kpm_cell import kpm_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  load_t  load,
  input  entry_t entry,
  input  tok_t   tok_in,
  output tok_t   tok_out
);

  logic [3:0]         len_r, len_nxt;
  logic [31:0]        code_r, code_nxt;
  tok_t               tok_r, tok_nxt;
  logic [ENTRY_W-1:0] code_ext;
  logic               miss;
  logic               hit;

  assign code_ext = {{(ENTRY_W-32){1'b0}}, code_r};

  always_comb begin
    miss = 1'b0;
    for (int i = 0; i < ENTRY_DIGITS; i++) begin
      if ((4'(i) < len_r) && (entry.code[4*i +: 4] != code_ext[4*i +: 4])) begin
        miss = 1'b1;
      end
    end
    hit = (len_r != 4'd0) && (len_r == entry.count) && !miss;
  end

  always_comb begin
    len_nxt  = len_r;
    code_nxt = code_r;
    if (load.valid && ({{(SLOT_W-4){1'b0}}, load.slot} == SLOT_W'(INDEX))) begin
      len_nxt  = load.length;
      code_nxt = load.code;
    end
    tok_nxt = tok_in;
    if (tok_in.valid && !tok_in.found && hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = SLOT_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 4'd0;
      tok_r <= '0;
    end else begin
      len_r <= len_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  assign tok_out = tok_r;

endmodule

/* rtl/core/kpm_ctrl.sv */
// Entry buffer, timers, limit registers and result register of the matcher.
module kpm_ctrl import kpm_pkg::*; #(
  parameter int BUFFER_SLOTS = BUFFER_SLOTS_DEF,
  parameter int PIN_DIGITS   = PIN_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output load_t                 load,
  output entry_t                entry,
  output tok_t                  tok_head,
  input  tok_t                  tok_tail
);

  logic               busy_r, busy_nxt;
  logic [ENTRY_W-1:0] code_r, code_nxt;
  logic [3:0]         count_r, count_nxt;
  logic [15:0]        gap_r, gap_nxt;
  logic [15:0]        elapsed_r, elapsed_nxt;
  logic [15:0]        gap_lim_r, gap_lim_nxt;
  logic [15:0]        entry_lim_r, entry_lim_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;
  tok_t               tok_head_r, tok_head_nxt;
  logic               accept;
  logic [15:0]        gap_inc;
  logic [15:0]        elapsed_inc;

  assign accept      = start && !busy_r;
  assign gap_inc     = (gap_r == TIMER_MAX) ? gap_r : gap_r + 16'd1;
  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    load.valid  = accept && (in_word.req_type == REQ_LOAD);
    load.slot   = in_word.load_slot;
    load.length = (in_word.load_length > 4'(PIN_DIGITS)) ? 4'd0 : in_word.load_length;
    load.code   = in_word.load_code;
  end

  always_comb begin
    gap_lim_nxt   = gap_lim_r;
    entry_lim_nxt = entry_lim_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAP_LIMIT:   gap_lim_nxt   = cfg_wdata;
        CFG_ENTRY_LIMIT: entry_lim_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    code_nxt      = code_r;
    count_nxt     = count_r;
    gap_nxt       = gap_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    tok_head_nxt  = '0;

    if (accept) begin
      unique case (in_word.req_type)
        REQ_DIGIT: begin
          if (count_r >= 4'(BUFFER_SLOTS - 1)) begin
            code_nxt    = '0;
            count_nxt   = 4'd0;
            gap_nxt     = 16'd0;
            elapsed_nxt = 16'd0;
          end else begin
            code_nxt[{count_r, 2'b00} +: 4] = in_word.key_digit;
            count_nxt          = count_r + 4'd1;
            tok_head_nxt.valid = 1'b1;
            busy_nxt           = 1'b1;
          end
        end
        REQ_TICK: begin
          gap_nxt     = gap_inc;
          elapsed_nxt = elapsed_inc;
          if ((count_r != 4'd0) && (gap_inc >= gap_lim_r)) begin
            out_valid_nxt               = 1'b1;
            out_word_nxt.is_match       = 1'b0;
            out_word_nxt.match_slot     = 4'd0;
            out_word_nxt.entered_code   = code_r;
            out_word_nxt.entered_length = count_r;
            out_word_nxt.cause          = 1'b1;
            code_nxt    = '0;
            count_nxt   = 4'd0;
            gap_nxt     = 16'd0;
            elapsed_nxt = 16'd0;
          end
          if (elapsed_inc >= entry_lim_r) begin
            code_nxt    = '0;
            count_nxt   = 4'd0;
            gap_nxt     = 16'd0;
            elapsed_nxt = 16'd0;
          end
        end
        REQ_LOAD: ;
        REQ_FLUSH: begin
          code_nxt    = '0;
          count_nxt   = 4'd0;
          gap_nxt     = 16'd0;
          elapsed_nxt = 16'd0;
        end
        default: ;
      endcase
    end

    // close the search: report, then drop the entry on a hit
    if (tok_tail.valid) begin
      busy_nxt                    = 1'b0;
      out_valid_nxt               = 1'b1;
      out_word_nxt.is_match       = tok_tail.found;
      out_word_nxt.match_slot     = tok_tail.found ? tok_tail.slot[3:0] : 4'd0;
      out_word_nxt.entered_code   = code_r;
      out_word_nxt.entered_length = count_r;
      out_word_nxt.cause          = 1'b0;
      gap_nxt                     = 16'd0;
      if (tok_tail.found) begin
        code_nxt    = '0;
        count_nxt   = 4'd0;
        elapsed_nxt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      code_r      <= '0;
      count_r     <= 4'd0;
      gap_r       <= 16'd0;
      elapsed_r   <= 16'd0;
      gap_lim_r   <= GAP_LIMIT_RST;
      entry_lim_r <= ENTRY_LIMIT_RST;
      out_valid_r <= 1'b0;
      tok_head_r  <= '0;
    end else begin
      busy_r      <= busy_nxt;
      code_r      <= code_nxt;
      count_r     <= count_nxt;
      gap_r       <= gap_nxt;
      elapsed_r   <= elapsed_nxt;
      gap_lim_r   <= gap_lim_nxt;
      entry_lim_r <= entry_lim_nxt;
      out_valid_r <= out_valid_nxt;
      tok_head_r  <= tok_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign entry.code  = code_r;
  assign entry.count = count_r;
  assign tok_head    = tok_head_r;

endmodule

/* bench/kpm_match_checker.sv */
`timescale 1ns / 100ps
// Checker for the keypad PIN code matcher: tracks entry, timers and PIN table, compares results.
module kpm_match_checker import kpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    pending
);

  localparam int HELD_MAX = BUFFER_SLOTS_DEF - 1;

  logic [15:0]        gap_limit;
  logic [15:0]        entry_limit;
  logic [15:0]        gap_ms;
  logic [15:0]        entry_ms;
  logic [ENTRY_W-1:0] held_code;
  logic [3:0]         held_count;
  logic [31:0]        pin_code [TABLE_ENTRIES_DEF];
  logic [3:0]         pin_len  [TABLE_ENTRIES_DEF];
  out_word_t          awaited_results [$];
  out_word_t          want;

  task automatic drop_entry();
    held_code  = '0;
    held_count = '0;
    gap_ms     = '0;
    entry_ms   = '0;
  endtask

  function automatic out_word_t entry_report(logic hit, logic [3:0] slot, logic cause);
    out_word_t w;
    w.is_match       = hit;
    w.match_slot     = slot;
    w.entered_code   = held_code;
    w.entered_length = held_count;
    w.cause          = cause;
    return w;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  task automatic step_matcher(in_word_t w);
    bit         found;
    bit         same;
    logic [3:0] hit;
    found = 1'b0;
    hit   = '0;
    case (w.req_type)
      REQ_DIGIT: begin
        if (held_count >= HELD_MAX) begin
          drop_entry();
        end else begin
          held_code[4*held_count +: 4] = w.key_digit;
          held_count++;
          for (int s = 0; s < TABLE_ENTRIES_DEF; s++) begin
            if (!found && pin_len[s] != 0 && pin_len[s] == held_count) begin
              same = 1'b1;
              for (int i = 0; i < pin_len[s] && i < PIN_DIGITS_DEF; i++) begin
                if (held_code[4*i +: 4] != pin_code[s][4*i +: 4]) same = 1'b0;
              end
              if (same) begin
                found = 1'b1;
                hit   = 4'(s);
              end
            end
          end
          if (found) begin
            awaited_results.push_back(entry_report(1'b1, hit, 1'b0));
            drop_entry();
          end else begin
            awaited_results.push_back(entry_report(1'b0, 4'd0, 1'b0));
            gap_ms = '0;
          end
        end
      end
      REQ_TICK: begin
        if (gap_ms != TIMER_MAX) gap_ms++;
        if (entry_ms != TIMER_MAX) entry_ms++;
        if (held_count != 0 && gap_ms >= gap_limit) begin
          awaited_results.push_back(entry_report(1'b0, 4'd0, 1'b1));
          drop_entry();
        end
        if (entry_ms >= entry_limit) drop_entry();
      end
      REQ_LOAD: begin
        pin_code[w.load_slot] = w.load_code;
        pin_len[w.load_slot]  = (w.load_length > PIN_DIGITS_DEF) ? 4'd0 : w.load_length;
      end
      default: begin
        drop_entry();
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gap_limit   = GAP_LIMIT_RST;
      entry_limit = ENTRY_LIMIT_RST;
      for (int s = 0; s < TABLE_ENTRIES_DEF; s++) begin
        pin_code[s] = '0;
        pin_len[s]  = '0;
      end
      drop_entry();
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h", $time, out_word);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("is_match", 64'(want.is_match), 64'(out_word.is_match));
          check_field("match_slot", 64'(want.match_slot), 64'(out_word.match_slot));
          check_field("entered_code", 64'(want.entered_code), 64'(out_word.entered_code));
          check_field("entered_length", 64'(want.entered_length),
                      64'(out_word.entered_length));
          check_field("cause", 64'(want.cause), 64'(out_word.cause));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAP_LIMIT:   gap_limit   = cfg_wdata;
          CFG_ENTRY_LIMIT: entry_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) step_matcher(in_word);
    end
    pending <= awaited_results.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the keypad PIN code matcher: stimulus, watchdog and verdict.
module tb_top;
  import kpm_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES_DEF + 8;
  localparam int PHASE_WORDS   = 110;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_word_t              in_word;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int          errors;
  int          pending;
  int          words_sent;
  int          burst_left;
  int          idle_cycles;
  int          phase_stop;
  logic [15:0] gap_now;
  logic [31:0] pin_code [TABLE_ENTRIES_DEF];
  logic [3:0]  pin_len  [TABLE_ENTRIES_DEF];

  keypad_pin_code_matcher_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kpm_match_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t noise_word();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return in_word_t'(v[$bits(in_word_t)-1:0]);
  endfunction

  task automatic send(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        start   <= 1'b0;
        in_word <= noise_word();
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic press(logic [3:0] d);
    in_word_t w;
    w           = noise_word();
    w.req_type  = REQ_DIGIT;
    w.key_digit = d;
    send(w);
  endtask

  task automatic tick_burst(int n);
    in_word_t w;
    repeat (n) begin
      w          = noise_word();
      w.req_type = REQ_TICK;
      send(w);
    end
  endtask

  task automatic flush_entry();
    in_word_t w;
    w          = noise_word();
    w.req_type = REQ_FLUSH;
    send(w);
  endtask

  task automatic load_pin(int s, int l, logic [31:0] c);
    in_word_t w;
    w             = noise_word();
    w.req_type    = REQ_LOAD;
    w.load_slot   = 4'(s);
    w.load_length = 4'(l);
    w.load_code   = c;
    send(w);
    pin_code[s] = c;
    pin_len[s]  = (l > PIN_DIGITS_DEF) ? 4'd0 : 4'(l);
  endtask

  task automatic set_limits(logic [15:0] gap, logic [15:0] ent);
    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAP_LIMIT;
    cfg_wdata <= gap;
    @(negedge clk);
    cfg_index <= CFG_ENTRY_LIMIT;
    cfg_wdata <= ent;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= 16'($urandom);
    gap_now    = gap;
    burst_left = 0;
  endtask

  task automatic random_action();
    int pick;
    int s;
    int n;
    int bad;
    int base;
    pick = $urandom_range(0, 99);
    base = $urandom_range(0, TABLE_ENTRIES_DEF - 1);
    s    = -1;
    for (int k = 0; k < TABLE_ENTRIES_DEF; k++) begin
      if (s < 0 && pin_len[(base + k) % TABLE_ENTRIES_DEF] != 0) s = (base + k) % TABLE_ENTRIES_DEF;
    end
    if (pick < 8) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, PIN_DIGITS_DEF);
      load_pin(base, n, $urandom);
    end else if (pick < 13) begin
      flush_entry();
    end else if (pick < 40) begin
      n = (gap_now > 30) ? 30 : gap_now + 2;
      tick_burst($urandom_range(1, n));
    end else if (pick < 85 && s >= 0) begin
      if ($urandom_range(0, 1) == 1) flush_entry();
      bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, pin_len[s] - 1) : -1;
      for (int i = 0; i < pin_len[s]; i++) begin
        press((i == bad) ? 4'($urandom) : pin_code[s][4*i +: 4]);
      end
    end else begin
      repeat ($urandom_range(1, 4)) press(4'($urandom));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    burst_left = 0;
    words_sent = 0;
    gap_now    = GAP_LIMIT_RST;
    for (int s = 0; s < TABLE_ENTRIES_DEF; s++) begin
      pin_code[s] = '0;
      pin_len[s]  = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_pin(0, 4, 32'h0000_4321);
    load_pin(3, 4, 32'h0000_4321);
    load_pin(15, 8, 32'hFEDC_BA98);
    load_pin(7, 9, 32'hFFFF_FFFF);
    load_pin(8, 0, 32'h0000_0000);
    press(4'd1);
    press(4'd2);
    press(4'd3);
    press(4'd4);
    press(4'd9);
    flush_entry();
    for (int d = 0; d < 16; d++) press(4'(d));
    tick_burst(1);

    set_limits(16'd0, 16'd0);
    press(4'd5);
    tick_burst(2);
    press(4'd5);
    press(4'd6);
    tick_burst(2);

    set_limits(16'd20, 16'd60000);
    press(4'd7);
    press(4'd7);
    tick_burst(25);

    set_limits(16'd60000, 16'd20);
    flush_entry();
    press(4'd6);
    tick_burst(25);
    press(4'd6);

    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        set_limits(16'hFFFF, 16'hFFFF);
      end else begin
        set_limits(16'($urandom_range(1, 25)), 16'($urandom_range(10, 150)));
      end
      phase_stop = words_sent + PHASE_WORDS;
      while (words_sent < phase_stop) random_action();
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
